/* hw/rtl/ptc_pkg.sv */
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and constants
// Calibration word layout, the item passed from the front part to the back
// part, register indexes and datapath widths.
// ----------------------------------------------------------------------------
package ptc_pkg;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_TEMP    = 2'd0;
  localparam logic [1:0] REG_PRESS_A = 2'd1;
  localparam logic [1:0] REG_PRESS_B = 2'd2;
  localparam logic [1:0] REG_PRESS_C = 2'd3;

  localparam int CFG_W   = 48;
  localparam int RAW_W   = 20;
  localparam int TEMP_W  = 18;
  localparam int FINE_W  = 24;
  localparam int PRESS_W = 32;

  // Width of the signed dividend and divisor of the pressure division.
  localparam int WN = 82;
  localparam int WD = 44;

  // Digit width of the multi-cycle multiplier.
  localparam int MUL_DW = 16;

  // Default depth of the queue between the front and the back part.
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } coeffs_t;

  typedef struct packed {
    logic signed [WN-1:0]     num;
    logic signed [WD-1:0]     den;
    logic                     bad;
    logic signed [TEMP_W-1:0] tc;
    logic signed [FINE_W-1:0] tf;
  } mid_item_t;

endpackage

/* hw/rtl/ptc_front.sv */
// ----------------------------------------------------------------------------
// ptc_front: temperature and pressure pre-terms
// Eight-stage pipeline computing the fine temperature, the temperature in
// hundredths of a degree and the dividend and divisor of the pressure step.
// ----------------------------------------------------------------------------
module ptc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [ptc_pkg::RAW_W-1:0]     raw_temp,
  input  logic [ptc_pkg::RAW_W-1:0]     raw_press,
  input  ptc_pkg::coeffs_t              coeffs,
  output logic                          out_valid,
  output ptc_pkg::mid_item_t            out_item
);

  localparam int WN = ptc_pkg::WN;
  localparam int WD = ptc_pkg::WD;
  localparam int FINE_W_LOC = ptc_pkg::FINE_W;

  // Offset of 2^47 added to the divisor sum before scaling by P1.
  localparam logic signed [61:0] DBIAS = 62'sh0000_8000_0000_0000;

  logic [7:0] vf;

  logic signed [15:0] t2s, t3s, p2s, p3s, p4s, p5s, p6s;
  logic signed [16:0] t1x, p1x;

  assign t1x = $signed({1'b0, coeffs.t1});
  assign p1x = $signed({1'b0, coeffs.p1});
  assign t2s = $signed(coeffs.t2);
  assign t3s = $signed(coeffs.t3);
  assign p2s = $signed(coeffs.p2);
  assign p3s = $signed(coeffs.p3);
  assign p4s = $signed(coeffs.p4);
  assign p5s = $signed(coeffs.p5);
  assign p6s = $signed(coeffs.p6);

  // Stage 0
  logic signed [17:0] ax;
  logic signed [16:0] dd;
  logic signed [33:0] a1p_0, ddsq_0;
  logic [19:0]        rp_0, rp_1, rp_2, rp_3, rp_4;

  assign ax = $signed({1'b0, raw_temp[19:3]}) - $signed({t1x, 1'b0});
  assign dd = $signed({1'b0, raw_temp[19:4]}) - t1x;

  // Stage 1
  logic signed [23:0] a1_1;
  logic signed [37:0] a2p_1;

  // Stage 2
  logic signed [24:0] tfw;
  logic signed [31:0] tcw;
  logic signed [FINE_W_LOC-1:0] tf_2, tf_3, tf_4, tf_5, tf_6;
  logic signed [17:0] tc_2, tc_3, tc_4, tc_5, tc_6;
  logic signed [25:0] v1_2;

  assign tfw = 25'(a1_1 + (a2p_1 >>> 14));
  assign tcw = (tfw * 5 + 128) >>> 8;

  // Stage 3
  logic signed [51:0] v1sq_3;
  logic signed [41:0] v1p5_3, v1p2_3, v1p5_4, v1p2_4;

  // Stage 4
  logic signed [67:0] t6_4, t3_4;

  // Stage 5
  logic signed [21:0] p0;
  logic signed [69:0] v2_5;
  logic signed [61:0] ds_5;
  logic signed [53:0] pp_5;

  assign p0 = 22'sd1048576 - $signed({2'b00, rp_4});

  // Stage 6
  logic signed [70:0] nm_6;
  logic signed [78:0] dm_6;

  // Stage 7
  logic signed [83:0] nw;
  logic signed [45:0] dsh;

  assign nw  = nm_6 * 14'sd3125;
  assign dsh = $signed(dm_6[78:33]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= '0;
    end else if (en) begin
      vf <= {vf[6:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1p_0  <= ax * t2s;
      ddsq_0 <= dd * dd;
      rp_0   <= raw_press;

      a1_1   <= 24'(a1p_0 >>> 11);
      a2p_1  <= (ddsq_0 >>> 12) * t3s;
      rp_1   <= rp_0;

      tf_2   <= tfw[23:0];
      tc_2   <= tcw[17:0];
      v1_2   <= 26'(tfw - 128000);
      rp_2   <= rp_1;

      v1sq_3 <= v1_2 * v1_2;
      v1p5_3 <= v1_2 * p5s;
      v1p2_3 <= v1_2 * p2s;
      tf_3   <= tf_2;
      tc_3   <= tc_2;
      rp_3   <= rp_2;

      t6_4   <= v1sq_3 * p6s;
      t3_4   <= v1sq_3 * p3s;
      v1p5_4 <= v1p5_3;
      v1p2_4 <= v1p2_3;
      tf_4   <= tf_3;
      tc_4   <= tc_3;
      rp_4   <= rp_3;

      v2_5   <= t6_4 + (v1p5_4 <<< 17) + (p4s <<< 35);
      ds_5   <= 62'((t3_4 >>> 8) + (v1p2_4 <<< 12) + DBIAS);
      pp_5   <= p0 <<< 31;
      tf_5   <= tf_4;
      tc_5   <= tc_4;

      nm_6   <= pp_5 - v2_5;
      dm_6   <= ds_5 * p1x;
      tf_6   <= tf_5;
      tc_6   <= tc_5;

      out_item.num <= $signed(nw[WN-1:0]);
      out_item.den <= $signed(dsh[WD-1:0]);
      out_item.bad <= (dsh == '0);
      out_item.tc  <= tc_6;
      out_item.tf  <= tf_6;
    end
  end

  assign out_valid = vf[7];

endmodule

/* hw/rtl/ptc_queue.sv */
// ----------------------------------------------------------------------------
// ptc_queue: short register queue
// Decouples the front part from the back part so that each can stall alone.
// ----------------------------------------------------------------------------
module ptc_queue #(
  parameter int W     = 8,
  parameter int DEPTH = ptc_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [CW-1:0] cnt;

  assign full  = (cnt == CW'(DEPTH));
  assign empty = (cnt == '0);
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

endmodule

/* hw/rtl/ptc_mul.sv */
// ----------------------------------------------------------------------------
// ptc_mul: pipelined wide signed multiplier
// One digit of the second operand is multiplied and accumulated per stage.
// ----------------------------------------------------------------------------
module ptc_mul #(
  parameter int WA = 8,
  parameter int WB = 8,
  parameter int DW = ptc_pkg::MUL_DW
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int NS    = (WB + DW - 1) / DW;
  localparam int WBX   = NS * DW;
  localparam int WACC  = WA + WBX;
  localparam int WPART = WA + DW + 1;

  logic signed [WBX-1:0]  bx;
  logic signed [WA-1:0]   ar  [NS];
  logic signed [WBX-1:0]  br  [NS];
  logic signed [WACC-1:0] acc [NS];

  assign bx = WBX'(b);

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic signed [WA-1:0]    a_in;
    logic signed [WBX-1:0]   b_in;
    logic signed [WACC-1:0]  acc_in;
    logic signed [DW:0]      dig;
    logic signed [WPART-1:0] part;
    logic signed [WACC-1:0]  part_x;

    if (k == 0) begin : g_first
      assign a_in   = a;
      assign b_in   = bx;
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = ar[k-1];
      assign b_in   = br[k-1];
      assign acc_in = acc[k-1];
    end

    // The top digit carries the sign of the operand.
    if (k == NS - 1) begin : g_top
      assign dig = $signed({b_in[k*DW+DW-1], b_in[k*DW +: DW]});
    end else begin : g_low
      assign dig = $signed({1'b0, b_in[k*DW +: DW]});
    end

    assign part   = a_in * dig;
    assign part_x = WACC'(part) <<< (k * DW);

    always_ff @(posedge clk) begin
      if (en) begin
        ar[k]  <= a_in;
        br[k]  <= b_in;
        acc[k] <= acc_in + part_x;
      end
    end
  end

  assign p = $signed(acc[NS-1][WA+WB-1:0]);

endmodule

/* hw/rtl/ptc_back.sv */
// ----------------------------------------------------------------------------
// ptc_back: pressure division and final correction
// Pipelined restoring divider (one quotient bit per stage), dig_P7, dig_P8
// and dig_P9 correction terms and saturation to the unsigned Q24.8 range.
// ----------------------------------------------------------------------------
module ptc_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              take,
  input  ptc_pkg::mid_item_t                item,
  input  ptc_pkg::coeffs_t                  coeffs,
  output logic                              res_valid,
  output logic signed [ptc_pkg::TEMP_W-1:0] temp_centi_c,
  output logic signed [ptc_pkg::FINE_W-1:0] fine_temp,
  output logic [ptc_pkg::PRESS_W-1:0]       pressure_q24_8,
  output logic                              press_invalid
);

  localparam int WN   = ptc_pkg::WN;
  localparam int WD   = ptc_pkg::WD;
  localparam int WP   = WN + 1;
  localparam int WPS  = WP - 13;
  localparam int WM1  = WPS + 16;
  localparam int WY   = WP + 16 - 19;
  localparam int WPR  = WM1 + WPS;
  localparam int WX   = WPR - 25;
  localparam int WSUM = WX + 2;
  localparam int WF   = WSUM - 7;
  localparam int NSM  = (WPS + ptc_pkg::MUL_DW - 1) / ptc_pkg::MUL_DW;
  localparam int L    = WN + 5 + NSM;

  typedef struct packed {
    logic                              qneg;
    logic                              bad;
    logic signed [ptc_pkg::TEMP_W-1:0] tc;
    logic signed [ptc_pkg::FINE_W-1:0] tf;
  } side_t;

  function automatic logic signed [WP-1:0] s_q_sel(input logic neg, input logic [WN-1:0] q);
    logic signed [WP-1:0] qx;
    qx = $signed({1'b0, q});
    return neg ? -qx : qx;
  endfunction

  logic [L-1:0] vld;

  logic signed [15:0] p7s, p8s, p9s;
  assign p7s = $signed(coeffs.p7);
  assign p8s = $signed(coeffs.p8);
  assign p9s = $signed(coeffs.p9);

  // Magnitude stage
  logic [WN-1:0] a0;
  logic [WD-1:0] d0;
  side_t         s0;

  // Divider stages
  logic [WN-1:0] dv_a [WN];
  logic [WD-1:0] dv_r [WN];
  logic [WD-1:0] dv_d [WN];
  side_t         dv_s [WN];

  // Sign, multiply, sum and result stages
  logic signed [WP-1:0]   p_q, p_m;
  side_t                  s_q, s_m;
  logic signed [WP-1:0]   psw;
  logic signed [WPS-1:0]  ps, ps_m;
  logic signed [WM1-1:0]  m1;
  logic signed [WP+15:0]  yp, yw;
  logic signed [WY-1:0]   y_m;
  logic signed [WPR-1:0]  prod;
  logic signed [WP-1:0]   mp_p [NSM];
  logic signed [WY-1:0]   mp_y [NSM];
  side_t                  mp_s [NSM];
  logic signed [WSUM-1:0] sum;
  side_t                  s_s;
  logic signed [19:0]     p7x;
  logic signed [WF-1:0]   f;
  logic [31:0]            sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0      <= item.num[WN-1] ? (~item.num + 1'b1) : item.num;
      d0      <= item.den[WD-1] ? (~item.den + 1'b1) : item.den;
      s0.qneg <= item.num[WN-1] ^ item.den[WD-1];
      s0.bad  <= item.bad;
      s0.tc   <= item.tc;
      s0.tf   <= item.tf;
    end
  end

  for (genvar i = 0; i < WN; i++) begin : g_div
    logic [WN-1:0] a_in;
    logic [WD-1:0] r_in, d_in;
    side_t         s_in;
    logic [WD:0]   t;
    logic [WD+1:0] diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign a_in = a0;
      assign r_in = '0;
      assign d_in = d0;
      assign s_in = s0;
    end else begin : g_next
      assign a_in = dv_a[i-1];
      assign r_in = dv_r[i-1];
      assign d_in = dv_d[i-1];
      assign s_in = dv_s[i-1];
    end

    assign t    = {r_in, a_in[WN-1]};
    assign diff = {1'b0, t} - {2'b00, d_in};
    assign ge   = ~diff[WD+1];

    always_ff @(posedge clk) begin
      if (en) begin
        dv_a[i] <= {a_in[WN-2:0], ge};
        dv_r[i] <= ge ? diff[WD-1:0] : t[WD-1:0];
        dv_d[i] <= d_in;
        dv_s[i] <= s_in;
      end
    end
  end

  assign psw = p_q >>> 13;
  assign ps  = $signed(psw[WPS-1:0]);
  assign yp  = p_q * p8s;
  assign yw  = yp >>> 19;

  always_ff @(posedge clk) begin
    if (en) begin
      p_q  <= s_q_sel(dv_s[WN-1].qneg, dv_a[WN-1]);
      s_q  <= dv_s[WN-1];

      m1   <= ps * p9s;
      ps_m <= ps;
      y_m  <= $signed(yw[WY-1:0]);
      p_m  <= p_q;
      s_m  <= s_q;
    end
  end

  ptc_mul #(
    .WA (WM1),
    .WB (WPS),
    .DW (ptc_pkg::MUL_DW)
  ) u_mul (
    .clk (clk),
    .en  (en),
    .a   (m1),
    .b   (ps_m),
    .p   (prod)
  );

  for (genvar k = 0; k < NSM; k++) begin : g_side
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          mp_p[k] <= p_m;
          mp_y[k] <= y_m;
          mp_s[k] <= s_m;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          mp_p[k] <= mp_p[k-1];
          mp_y[k] <= mp_y[k-1];
          mp_s[k] <= mp_s[k-1];
        end
      end
    end
  end

  assign p7x = $signed({p7s, 4'b0000});
  assign f   = WF'((sum >>> 8) + p7x);

  always_comb begin
    if (f[WF-1]) begin
      sat = '0;
    end else if (|f[WF-2:32]) begin
      sat = '1;
    end else begin
      sat = f[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= WSUM'(mp_p[NSM-1] + (prod >>> 25) + mp_y[NSM-1]);
      s_s <= mp_s[NSM-1];

      temp_centi_c   <= s_s.tc;
      fine_temp      <= s_s.tf;
      pressure_q24_8 <= s_s.bad ? '0 : sat;
      press_invalid  <= s_s.bad;
    end
  end

  assign res_valid = vld[L-1];

endmodule

/* hw/rtl/pressure_temp_compensation_core.sv */
// ----------------------------------------------------------------------------
// pressure_temp_compensation_core: barometric compensation engine
// Takes one raw temperature and one raw pressure sample per item and returns
// the compensated temperature (0.01 degC), the fine temperature and the
// pressure in pascals as unsigned Q24.8. Items are accepted at a sustained
// rate of one per clock cycle while full is low. An accepted item passes
// through the front pipeline, the queue and then the back pipeline to its
// result.
// The back pipeline length is set by the restoring divider, which resolves
// one quotient bit per stage, and the multi-digit multiplier of the dig_P9
// term. A zero divisor gives pressure 0 with press_invalid set; the
// temperature fields are still valid. Calibration registers must only be
// written while no item is in flight.
// ----------------------------------------------------------------------------
module pressure_temp_compensation_core #(
  parameter int QUEUE_DEPTH = ptc_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,

  // Sample input, queue style.
  input  logic                              push,
  output logic                              full,
  input  logic [ptc_pkg::RAW_W-1:0]         raw_temp,
  input  logic [ptc_pkg::RAW_W-1:0]         raw_press,

  // Results, queue style.
  output logic                              empty,
  input  logic                              pop,
  output logic signed [ptc_pkg::TEMP_W-1:0] temp_centi_c,
  output logic signed [ptc_pkg::FINE_W-1:0] fine_temp,
  output logic [ptc_pkg::PRESS_W-1:0]       pressure_q24_8,
  output logic                              press_invalid,

  // Calibration register writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [ptc_pkg::CFG_W-1:0]         cfg_data
);

  // Calibration registers, each holding three sixteen-bit words.
  logic [ptc_pkg::CFG_W-1:0] temp_coeffs;
  logic [ptc_pkg::CFG_W-1:0] press_coeffs_a;
  logic [ptc_pkg::CFG_W-1:0] press_coeffs_b;
  logic [ptc_pkg::CFG_W-1:0] press_coeffs_c;

  ptc_pkg::coeffs_t coeffs;

  // Front pipeline, queue and back pipeline handshake.
  logic               en_f, en_b;
  logic               front_valid;
  ptc_pkg::mid_item_t front_item;
  logic               q_push, q_full, q_pop, q_empty;
  ptc_pkg::mid_item_t q_item;
  logic               res_valid;

  // The port accepts a write in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs    <= '0;
      press_coeffs_a <= '0;
      press_coeffs_b <= '0;
      press_coeffs_c <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ptc_pkg::REG_TEMP:    temp_coeffs    <= cfg_data;
        ptc_pkg::REG_PRESS_A: press_coeffs_a <= cfg_data;
        ptc_pkg::REG_PRESS_B: press_coeffs_b <= cfg_data;
        ptc_pkg::REG_PRESS_C: press_coeffs_c <= cfg_data;
      endcase
    end
  end

  // Unpack the calibration words.
  assign coeffs.t1 = temp_coeffs[15:0];
  assign coeffs.t2 = temp_coeffs[31:16];
  assign coeffs.t3 = temp_coeffs[47:32];
  assign coeffs.p1 = press_coeffs_a[15:0];
  assign coeffs.p2 = press_coeffs_a[31:16];
  assign coeffs.p3 = press_coeffs_a[47:32];
  assign coeffs.p4 = press_coeffs_b[15:0];
  assign coeffs.p5 = press_coeffs_b[31:16];
  assign coeffs.p6 = press_coeffs_b[47:32];
  assign coeffs.p7 = press_coeffs_c[15:0];
  assign coeffs.p8 = press_coeffs_c[31:16];
  assign coeffs.p9 = press_coeffs_c[47:32];

  // The front pipeline advances unless its last item cannot enter the queue.
  assign en_f   = !front_valid || !q_full;
  assign full   = !en_f;
  assign q_push = front_valid && !q_full;

  // The back pipeline advances unless a finished result is still waiting.
  assign en_b  = !res_valid || pop;
  assign q_pop = en_b && !q_empty;
  assign empty = !res_valid;

  ptc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en_f),
    .in_valid  (push),
    .raw_temp  (raw_temp),
    .raw_press (raw_press),
    .coeffs    (coeffs),
    .out_valid (front_valid),
    .out_item  (front_item)
  );

  ptc_queue #(
    .W     ($bits(ptc_pkg::mid_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (front_item),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_item),
    .empty (q_empty)
  );

  ptc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .en             (en_b),
    .take           (q_pop),
    .item           (q_item),
    .coeffs         (coeffs),
    .res_valid      (res_valid),
    .temp_centi_c   (temp_centi_c),
    .fine_temp      (fine_temp),
    .pressure_q24_8 (pressure_q24_8),
    .press_invalid  (press_invalid)
  );

  // The input side only stalls when the queue cannot take the front item.
  a_full_needs_queue_full: assert property (@(posedge clk) disable iff (rst)
    full |-> q_full)
    else $error("input stalled while the queue had room");

  // A flagged result always carries zero pressure.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && press_invalid) |-> (pressure_q24_8 == '0))
    else $error("invalid pressure result is not zero");

  // A stalled back pipeline never drains the queue.
  a_no_pop_stalled: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !pop) |-> !q_pop)
    else $error("queue popped while the result was held");

endmodule
